// ===== rtl/cfp_pkg.sv =====
// shared types and constants of the circumcircle block
`default_nettype none

package cfp_pkg;

    // field widths of a result beat
    localparam int CENTRE_W = 32;
    localparam int RADIUS_W = 42;

    // largest radius code
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};

    // control that travels with each item from cell to cell
    typedef struct packed {
        logic valid;
    } t_link;

endpackage

`default_nettype wire

// ===== rtl/cfp_div_cell.sv =====
// one restoring division step: brings in one numerator bit, yields one quotient bit
`default_nettype none

module cfp_div_cell #(
    parameter int NUM_W  = 40,
    parameter int DEN_W  = 27,
    parameter int SIDE_W = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  cfp_pkg::t_link      i_link,
    input  wire [DEN_W-1:0]     i_rem,
    input  wire [NUM_W-1:0]     i_numq,
    input  wire [DEN_W-1:0]     i_den,
    input  wire [SIDE_W-1:0]    i_side,
    output cfp_pkg::t_link      o_link,
    output logic [DEN_W-1:0]    o_rem,
    output logic [NUM_W-1:0]    o_numq,
    output logic [DEN_W-1:0]    o_den,
    output logic [SIDE_W-1:0]   o_side
);
    import cfp_pkg::*;

    t_link              r_link;
    logic [DEN_W:0]     w_trial;
    logic [DEN_W:0]     w_diff;
    logic               w_ge;
    logic [DEN_W-1:0]   n_rem;
    logic [NUM_W-1:0]   n_numq;

    // partial remainder with the next numerator bit shifted in
    assign w_trial = {i_rem, i_numq[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    // subtract when it fits, quotient bit enters at the bottom
    always_comb begin
        n_rem  = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        n_numq = {i_numq[NUM_W-2:0], w_ge};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else if (i_en) begin
            r_link <= i_link;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_numq <= n_numq;
            o_den  <= i_den;
            o_side <= i_side;
        end
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

// ===== rtl/cfp_sqrt_cell.sv =====
// one restoring square root step: takes two radicand bits, yields one root bit
`default_nettype none

module cfp_sqrt_cell #(
    parameter int ROOT_W = 45,
    parameter int SIDE_W = 8
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  cfp_pkg::t_link          i_link,
    input  wire [2*ROOT_W-1:0]      i_rad,
    input  wire [ROOT_W-1:0]        i_root,
    input  wire [ROOT_W:0]          i_rem,
    input  wire [SIDE_W-1:0]        i_side,
    output cfp_pkg::t_link          o_link,
    output logic [2*ROOT_W-1:0]     o_rad,
    output logic [ROOT_W-1:0]       o_root,
    output logic [ROOT_W:0]         o_rem,
    output logic [SIDE_W-1:0]       o_side
);
    import cfp_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;

    t_link              r_link;
    logic [ROOT_W+2:0]  w_acc;
    logic [ROOT_W+2:0]  w_test;
    logic [ROOT_W+2:0]  w_diff;
    logic               w_ge;
    logic [ROOT_W:0]    n_rem;
    logic [ROOT_W-1:0]  n_root;
    logic [RAD_W-1:0]   n_rad;

    // remainder with the next bit pair, against 4*root+1
    assign w_acc  = {i_rem, i_rad[RAD_W-1 -: 2]};
    assign w_test = {1'b0, i_root, 2'b01};
    assign w_diff = w_acc - w_test;
    assign w_ge   = (w_acc >= w_test);

    always_comb begin
        n_rem  = w_ge ? w_diff[ROOT_W:0] : w_acc[ROOT_W:0];
        n_root = {i_root[ROOT_W-2:0], w_ge};
        n_rad  = {i_rad[RAD_W-3:0], 2'b00};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else if (i_en) begin
            r_link <= i_link;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= n_rad;
            o_root <= n_root;
            o_rem  <= n_rem;
            o_side <= i_side;
        end
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

// ===== rtl/circle_from_three_points_core.sv =====
// circumcircle of three pixel points: front arithmetic and cell chains
//
// Input beat on the s channel carries three points A, B, C; output beat on
// the m channel carries the rounded centre, the radius in fixed point with
// RADIUS_FRAC_BITS fraction bits (measured to B), and tuser set when the
// points are collinear (all data fields then zero).
// One beat is taken every cycle while the chain is not held. With
// RW = 3*COORD_BITS + 5 + RADIUS_FRAC_BITS and CW = 3*COORD_BITS + 4, the
// path is: ten front stages of products and sums, a square root chain of
// RW cells, a radius division chain of RW cells, two side by side centre
// division chains of CW cells, and the output register.
// Every cell handles one bit of its result per cycle.
// Reset clears all valid flags; no beat is shown until a new one arrives.
// While the receiver stalls with a result waiting, the chain keeps moving
// and taking beats until its last cell holds an item; then the whole chain
// holds and o_s_tready drops.
`default_nettype none

module circle_from_three_points_core #(
    parameter int COORD_BITS       = 12,
    parameter int RADIUS_FRAC_BITS = 4
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  wire [((6*COORD_BITS+7)/8)*8-1:0]    i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // center_x, center_y, radius_q4
    output logic [((2*cfp_pkg::CENTRE_W+cfp_pkg::RADIUS_W+7)/8)*8-1:0] o_m_tdata,
    // collinear
    output logic                                o_m_tuser
);
    import cfp_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = RADIUS_FRAC_BITS;
    localparam int OW    = ((2*CENTRE_W+RADIUS_W+7)/8)*8;
    localparam int SQ_W  = 2*C+1;
    localparam int DF_W  = C+1;
    localparam int UV_W  = 2*C+2;
    localparam int DN_W  = 2*C+2;
    localparam int DD_W  = 2*C+3;
    localparam int DM_W  = 2*C+2;
    localparam int NX_W  = 3*C+3;
    localparam int CN_W  = 3*C+4;
    localparam int CD_W  = 2*C+3;
    localparam int EX_W  = 3*C+4;
    localparam int EM_W  = 3*C+3;
    localparam int LO_W  = (EM_W+1)/2;
    localparam int HI_W  = EM_W-LO_W;
    localparam int QX_W  = 2*EM_W;
    localparam int RT_W  = 3*C+5+F;
    localparam int S_W   = 2*RT_W;
    localparam int SB1_W = 3+CD_W+2*CN_W+DM_W;
    localparam int SB2_W = 3+CD_W+2*CN_W;
    localparam int SBX_W = 2+RT_W;
    localparam int ZW    = (CN_W > 33) ? CN_W : 33;
    localparam int KW    = (RT_W > RADIUS_W) ? RT_W : RADIUS_W;

    // stage valid flags of the front
    logic [10:1]                r_vld;
    logic                       w_en;
    logic                       w_end_valid;

    // stage 1
    logic [SQ_W-1:0]            r1_sa, r1_sb, r1_sc;
    logic signed [DF_W-1:0]     r1_dxab, r1_dyab, r1_dxbc, r1_dybc;
    logic [C-1:0]               r1_xb, r1_yb;
    logic [C-1:0]               w_xa, w_ya, w_xb, w_yb, w_xc, w_yc;
    // stage 2
    logic signed [UV_W-1:0]     r2_u, r2_v;
    logic signed [DN_W-1:0]     r2_p1, r2_p2;
    logic signed [DF_W-1:0]     r2_dxab, r2_dyab, r2_dxbc, r2_dybc;
    logic [C-1:0]               r2_xb, r2_yb;
    // stage 3
    logic signed [DN_W-1:0]     r3_dn;
    logic signed [NX_W-1:0]     r3_m1, r3_m2, r3_m3, r3_m4;
    logic [C-1:0]               r3_xb, r3_yb;
    // stage 4
    logic signed [NX_W-1:0]     r4_nx, r4_ny;
    logic signed [DD_W-1:0]     r4_dd;
    logic                       r4_col;
    logic [C-1:0]               r4_xb, r4_yb;
    // stage 5
    logic signed [EX_W-1:0]     r5_px, r5_py;
    logic signed [NX_W-1:0]     r5_nx, r5_ny;
    logic [SB1_W-1:0]           r5_side;
    logic [NX_W-1:0]            w_ax, w_ay;
    logic [DD_W-1:0]            w_bdd;
    logic [DM_W-1:0]            w_bd;
    logic [CN_W-1:0]            w_numx, w_numy;
    logic [CD_W-1:0]            w_cden;
    // stage 6 to 10
    logic signed [EX_W-1:0]     r6_ex, r6_ey;
    logic [SB1_W-1:0]           r6_side, r7_side, r8_side, r9_side, r10_side;
    logic [EM_W-1:0]            r7_mx, r7_my;
    logic [2*HI_W-1:0]          r8_hhx, r8_hhy;
    logic [EM_W-1:0]            r8_hlx, r8_hly;
    logic [2*LO_W-1:0]          r8_llx, r8_lly;
    logic [QX_W-1:0]            r9_qx, r9_qy;
    logic [S_W-1:0]             r10_s;

    // square root chain
    t_link                      w_sq_link [0:RT_W];
    logic [S_W-1:0]             w_sq_rad  [0:RT_W];
    logic [RT_W-1:0]            w_sq_root [0:RT_W];
    logic [RT_W:0]              w_sq_rem  [0:RT_W];
    logic [SB1_W-1:0]           w_sq_side [0:RT_W];
    // radius division chain
    t_link                      w_rd_link [0:RT_W];
    logic [DM_W-1:0]            w_rd_rem  [0:RT_W];
    logic [RT_W-1:0]            w_rd_numq [0:RT_W];
    logic [DM_W-1:0]            w_rd_den  [0:RT_W];
    logic [SB2_W-1:0]           w_rd_side [0:RT_W];
    logic [RT_W:0]              w_t1;
    logic [RT_W-1:0]            w_k;
    // centre division chains
    t_link                      w_cx_link [0:CN_W];
    logic [CD_W-1:0]            w_cx_rem  [0:CN_W];
    logic [CN_W-1:0]            w_cx_numq [0:CN_W];
    logic [CD_W-1:0]            w_cx_den  [0:CN_W];
    logic [SBX_W-1:0]           w_cx_side [0:CN_W];
    t_link                      w_cy_link [0:CN_W];
    logic [CD_W-1:0]            w_cy_rem  [0:CN_W];
    logic [CN_W-1:0]            w_cy_numq [0:CN_W];
    logic [CD_W-1:0]            w_cy_den  [0:CN_W];
    logic [0:0]                 w_cy_side [0:CN_W];

    // output register
    logic                       r_ov;
    logic [CENTRE_W-1:0]        r_cx, r_cy;
    logic [RADIUS_W-1:0]        r_rad;
    logic                       r_col;
    logic [CENTRE_W-1:0]        n_cx, n_cy;
    logic [RADIUS_W-1:0]        n_rad;
    logic                       n_col;
    logic [KW-1:0]              w_kz;

    // rounded quotient to a saturated signed centre
    function automatic logic [CENTRE_W-1:0] sat_centre(input logic [ZW-1:0] q,
                                                       input logic neg);
        logic [ZW-1:0] lim;
        logic [ZW-1:0] m;
        lim = neg ? ZW'(64'h8000_0000) : ZW'(64'h7FFF_FFFF);
        m   = (q > lim) ? lim : q;
        return neg ? CENTRE_W'(ZW'(0) - m) : CENTRE_W'(m);
    endfunction

    // the chain holds only when its last item cannot leave
    assign w_en       = !(w_end_valid && r_ov && !i_m_tready);
    assign o_s_tready = w_en;

    // input fields
    assign w_xa = i_s_tdata[0*C +: C];
    assign w_ya = i_s_tdata[1*C +: C];
    assign w_xb = i_s_tdata[2*C +: C];
    assign w_yb = i_s_tdata[3*C +: C];
    assign w_xc = i_s_tdata[4*C +: C];
    assign w_yc = i_s_tdata[5*C +: C];

    // front valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[9:1], i_s_tvalid};
        end
    end

    // centre numerators and twice the denominator magnitude
    always_comb begin
        w_ax   = r4_nx[NX_W-1] ? $unsigned(-r4_nx) : $unsigned(r4_nx);
        w_ay   = r4_ny[NX_W-1] ? $unsigned(-r4_ny) : $unsigned(r4_ny);
        w_bdd  = r4_dd[DD_W-1] ? $unsigned(-r4_dd) : $unsigned(r4_dd);
        w_bd   = w_bdd[DM_W-1:0];
        w_numx = {w_ax, 1'b0} + CN_W'(w_bd);
        w_numy = {w_ay, 1'b0} + CN_W'(w_bd);
        w_cden = {w_bd, 1'b0};
    end

    // front arithmetic stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // squares and differences
            r1_sa   <= SQ_W'(w_xa * w_xa) + SQ_W'(w_ya * w_ya);
            r1_sb   <= SQ_W'(w_xb * w_xb) + SQ_W'(w_yb * w_yb);
            r1_sc   <= SQ_W'(w_xc * w_xc) + SQ_W'(w_yc * w_yc);
            r1_dxab <= $signed({1'b0, w_xa}) - $signed({1'b0, w_xb});
            r1_dyab <= $signed({1'b0, w_ya}) - $signed({1'b0, w_yb});
            r1_dxbc <= $signed({1'b0, w_xb}) - $signed({1'b0, w_xc});
            r1_dybc <= $signed({1'b0, w_yb}) - $signed({1'b0, w_yc});
            r1_xb   <= w_xb;
            r1_yb   <= w_yb;
            // square differences and determinant products
            r2_u    <= $signed({1'b0, r1_sa}) - $signed({1'b0, r1_sb});
            r2_v    <= $signed({1'b0, r1_sb}) - $signed({1'b0, r1_sc});
            r2_p1   <= r1_dxab * r1_dybc;
            r2_p2   <= r1_dxbc * r1_dyab;
            r2_dxab <= r1_dxab;
            r2_dyab <= r1_dyab;
            r2_dxbc <= r1_dxbc;
            r2_dybc <= r1_dybc;
            r2_xb   <= r1_xb;
            r2_yb   <= r1_yb;
            // determinant and numerator products
            r3_dn   <= r2_p1 - r2_p2;
            r3_m1   <= r2_u * r2_dybc;
            r3_m2   <= r2_v * r2_dyab;
            r3_m3   <= r2_v * r2_dxab;
            r3_m4   <= r2_u * r2_dxbc;
            r3_xb   <= r2_xb;
            r3_yb   <= r2_yb;
            // centre numerators and doubled determinant
            r4_nx   <= r3_m1 - r3_m2;
            r4_ny   <= r3_m3 - r3_m4;
            r4_dd   <= {r3_dn, 1'b0};
            r4_col  <= (r3_dn == '0);
            r4_xb   <= r3_xb;
            r4_yb   <= r3_yb;
            // point b scaled by the denominator, centre division operands
            r5_px   <= $signed({1'b0, r4_xb}) * r4_dd;
            r5_py   <= $signed({1'b0, r4_yb}) * r4_dd;
            r5_nx   <= r4_nx;
            r5_ny   <= r4_ny;
            r5_side <= {r4_col, r4_ny[NX_W-1] ^ r4_dd[DD_W-1],
                        r4_nx[NX_W-1] ^ r4_dd[DD_W-1], w_cden, w_numy, w_numx, w_bd};
            // scaled offset from centre to b
            r6_ex   <= r5_px - r5_nx;
            r6_ey   <= r5_py - r5_ny;
            r6_side <= r5_side;
            // magnitudes
            r7_mx   <= r6_ex[EX_W-1] ? EM_W'($unsigned(-r6_ex)) : EM_W'($unsigned(r6_ex));
            r7_my   <= r6_ey[EX_W-1] ? EM_W'($unsigned(-r6_ey)) : EM_W'($unsigned(r6_ey));
            r7_side <= r6_side;
            // squares as partial products of halves
            r8_hhx  <= r7_mx[EM_W-1:LO_W] * r7_mx[EM_W-1:LO_W];
            r8_hlx  <= r7_mx[EM_W-1:LO_W] * r7_mx[LO_W-1:0];
            r8_llx  <= r7_mx[LO_W-1:0] * r7_mx[LO_W-1:0];
            r8_hhy  <= r7_my[EM_W-1:LO_W] * r7_my[EM_W-1:LO_W];
            r8_hly  <= r7_my[EM_W-1:LO_W] * r7_my[LO_W-1:0];
            r8_lly  <= r7_my[LO_W-1:0] * r7_my[LO_W-1:0];
            r8_side <= r7_side;
            // partial products summed
            r9_qx   <= (QX_W'(r8_hhx) << (2*LO_W)) + (QX_W'(r8_hlx) << (LO_W+1))
                       + QX_W'(r8_llx);
            r9_qy   <= (QX_W'(r8_hhy) << (2*LO_W)) + (QX_W'(r8_hly) << (LO_W+1))
                       + QX_W'(r8_lly);
            r9_side <= r8_side;
            // radicand scaled by four to the power of fraction bits plus one
            r10_s    <= (S_W'(r9_qx) + S_W'(r9_qy)) << (2*F+2);
            r10_side <= r9_side;
        end
    end

    // square root chain head
    assign w_sq_link[0].valid = r_vld[10];
    assign w_sq_rad[0]        = r10_s;
    assign w_sq_root[0]       = '0;
    assign w_sq_rem[0]        = '0;
    assign w_sq_side[0]       = r10_side;

    for (genvar gi = 0; gi < RT_W; gi++) begin : g_sqrt
        cfp_sqrt_cell #(
            .ROOT_W (RT_W),
            .SIDE_W (SB1_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_link  (w_sq_link[gi]),
            .i_rad   (w_sq_rad[gi]),
            .i_root  (w_sq_root[gi]),
            .i_rem   (w_sq_rem[gi]),
            .i_side  (w_sq_side[gi]),
            .o_link  (w_sq_link[gi+1]),
            .o_rad   (w_sq_rad[gi+1]),
            .o_root  (w_sq_root[gi+1]),
            .o_rem   (w_sq_rem[gi+1]),
            .o_side  (w_sq_side[gi+1])
        );
    end

    // radius division: integer root over the denominator magnitude
    assign w_rd_link[0] = w_sq_link[RT_W];
    assign w_rd_rem[0]  = '0;
    assign w_rd_numq[0] = w_sq_root[RT_W];
    assign w_rd_den[0]  = w_sq_side[RT_W][DM_W-1:0];
    assign w_rd_side[0] = w_sq_side[RT_W][SB1_W-1:DM_W];

    for (genvar gi = 0; gi < RT_W; gi++) begin : g_rdiv
        cfp_div_cell #(
            .NUM_W  (RT_W),
            .DEN_W  (DM_W),
            .SIDE_W (SB2_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_link  (w_rd_link[gi]),
            .i_rem   (w_rd_rem[gi]),
            .i_numq  (w_rd_numq[gi]),
            .i_den   (w_rd_den[gi]),
            .i_side  (w_rd_side[gi]),
            .o_link  (w_rd_link[gi+1]),
            .o_rem   (w_rd_rem[gi+1]),
            .o_numq  (w_rd_numq[gi+1]),
            .o_den   (w_rd_den[gi+1]),
            .o_side  (w_rd_side[gi+1])
        );
    end

    // largest odd multiple that fits gives the radius code
    assign w_t1 = {1'b0, w_rd_numq[RT_W]} + (RT_W+1)'(1);
    assign w_k  = w_t1[RT_W:1];

    // centre division chain heads
    assign w_cx_link[0] = w_rd_link[RT_W];
    assign w_cx_rem[0]  = '0;
    assign w_cx_numq[0] = w_rd_side[RT_W][CN_W-1:0];
    assign w_cx_den[0]  = w_rd_side[RT_W][2*CN_W +: CD_W];
    assign w_cx_side[0] = {w_rd_side[RT_W][2*CN_W+CD_W+2],
                           w_rd_side[RT_W][2*CN_W+CD_W], w_k};
    assign w_cy_link[0] = w_rd_link[RT_W];
    assign w_cy_rem[0]  = '0;
    assign w_cy_numq[0] = w_rd_side[RT_W][CN_W +: CN_W];
    assign w_cy_den[0]  = w_rd_side[RT_W][2*CN_W +: CD_W];
    assign w_cy_side[0] = w_rd_side[RT_W][2*CN_W+CD_W+1];

    for (genvar gi = 0; gi < CN_W; gi++) begin : g_cdiv
        cfp_div_cell #(
            .NUM_W  (CN_W),
            .DEN_W  (CD_W),
            .SIDE_W (SBX_W)
        ) u_xcell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_link  (w_cx_link[gi]),
            .i_rem   (w_cx_rem[gi]),
            .i_numq  (w_cx_numq[gi]),
            .i_den   (w_cx_den[gi]),
            .i_side  (w_cx_side[gi]),
            .o_link  (w_cx_link[gi+1]),
            .o_rem   (w_cx_rem[gi+1]),
            .o_numq  (w_cx_numq[gi+1]),
            .o_den   (w_cx_den[gi+1]),
            .o_side  (w_cx_side[gi+1])
        );

        cfp_div_cell #(
            .NUM_W  (CN_W),
            .DEN_W  (CD_W),
            .SIDE_W (1)
        ) u_ycell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_link  (w_cy_link[gi]),
            .i_rem   (w_cy_rem[gi]),
            .i_numq  (w_cy_numq[gi]),
            .i_den   (w_cy_den[gi]),
            .i_side  (w_cy_side[gi]),
            .o_link  (w_cy_link[gi+1]),
            .o_rem   (w_cy_rem[gi+1]),
            .o_numq  (w_cy_numq[gi+1]),
            .o_den   (w_cy_den[gi+1]),
            .o_side  (w_cy_side[gi+1])
        );
    end

    assign w_end_valid = w_cx_link[CN_W].valid & w_cy_link[CN_W].valid;

    // final saturation and the collinear case
    always_comb begin
        w_kz  = KW'(w_cx_side[CN_W][RT_W-1:0]);
        n_col = w_cx_side[CN_W][RT_W+1];
        if (n_col) begin
            n_cx  = '0;
            n_cy  = '0;
            n_rad = '0;
        end else begin
            n_cx  = sat_centre(ZW'(w_cx_numq[CN_W]), w_cx_side[CN_W][RT_W]);
            n_cy  = sat_centre(ZW'(w_cy_numq[CN_W]), w_cy_side[CN_W][0]);
            n_rad = (w_kz > KW'(RADIUS_MAX)) ? RADIUS_MAX : RADIUS_W'(w_kz);
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_end_valid && (!r_ov || i_m_tready)) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_end_valid && (!r_ov || i_m_tready)) begin
            r_cx  <= n_cx;
            r_cy  <= n_cy;
            r_rad <= n_rad;
            r_col <= n_col;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = OW'({r_rad, r_cy, r_cx});
    assign o_m_tuser  = r_col;

endmodule

`default_nettype wire

// ===== tb/circle_from_three_points_core_checker.sv =====
// checker for the circumcircle block: predicts each result beat and compares
`timescale 1ns / 100ps

module circle_from_three_points_core_checker #(
    parameter int COORD_BITS       = 12,
    parameter int RADIUS_FRAC_BITS = 4
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    input  wire                                 i_s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  wire [((6*COORD_BITS+7)/8)*8-1:0]    i_s_tdata,
    input  wire                                 i_m_tvalid,
    input  wire                                 i_m_tready,
    // center_x, center_y, radius_q4
    input  wire [((2*cfp_pkg::CENTRE_W+cfp_pkg::RADIUS_W+7)/8)*8-1:0] i_m_tdata,
    // collinear
    input  wire                                 i_m_tuser,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    import cfp_pkg::*;

    typedef struct {
        logic [CENTRE_W-1:0] centre_x;
        logic [CENTRE_W-1:0] centre_y;
        logic [RADIUS_W-1:0] radius;
        logic                collinear;
    } t_circle;

    t_circle circles_due[$];
    int      fail_count = 0;
    int      due_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = due_count;

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // integer square root, floor
    function automatic logic [127:0] isqrt(input logic [127:0] n);
        logic [127:0] rest;
        logic [127:0] root;
        logic [127:0] bitpos;
        rest   = n;
        root   = 0;
        bitpos = 128'd1 << 126;
        while (bitpos > rest) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (rest >= root + bitpos) begin
                rest = rest - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // nearest integer of num/den, ties away from zero, clipped to 32 bits
    function automatic logic [CENTRE_W-1:0] round_centre(input longint num,
                                                         input longint den);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q;
        a = magnitude(num);
        b = magnitude(den);
        q = (2 * a + b) / (2 * b);
        if ((num < 0) != (den < 0)) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return -q;
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q;
    endfunction

    function automatic t_circle circle_through(input logic [6*COORD_BITS-1:0] pts);
        longint       xa, ya, xb, yb, xc, yc;
        longint       u, v, dxab, dyab, dxbc, dybc, det, nx, ny, dd, ex, ey;
        logic [127:0] sq;
        logic [127:0] steps;
        t_circle      c;
        xa = pts[0*COORD_BITS +: COORD_BITS];
        ya = pts[1*COORD_BITS +: COORD_BITS];
        xb = pts[2*COORD_BITS +: COORD_BITS];
        yb = pts[3*COORD_BITS +: COORD_BITS];
        xc = pts[4*COORD_BITS +: COORD_BITS];
        yc = pts[5*COORD_BITS +: COORD_BITS];
        u    = (xa * xa + ya * ya) - (xb * xb + yb * yb);
        v    = (xb * xb + yb * yb) - (xc * xc + yc * yc);
        dxab = xa - xb;
        dyab = ya - yb;
        dxbc = xb - xc;
        dybc = yb - yc;
        det  = dxab * dybc - dxbc * dyab;
        c = '{default: 0};
        if (det == 0) begin
            c.collinear = 1'b1;
            return c;
        end
        nx = u * dybc - v * dyab;
        ny = v * dxab - u * dxbc;
        dd = 2 * det;
        c.centre_x = round_centre(nx, dd);
        c.centre_y = round_centre(ny, dd);
        // radius * 2^F rounded: largest k with (2k-1)|dd| <= sqrt(4^(F+1) * r2)
        ex = xb * dd - nx;
        ey = yb * dd - ny;
        sq = {64'd0, magnitude(ex)} * {64'd0, magnitude(ex)}
           + {64'd0, magnitude(ey)} * {64'd0, magnitude(ey)};
        sq = sq << (2 * RADIUS_FRAC_BITS + 2);
        steps = isqrt(sq) / {64'd0, magnitude(dd)};
        steps = (steps + 1) >> 1;
        c.radius = (steps > {86'd0, RADIUS_MAX}) ? RADIUS_MAX : steps[RADIUS_W-1:0];
        return c;
    endfunction

    // predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_circle want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                circles_due.insert(circles_due.size(),
                                   circle_through(i_s_tdata[6*COORD_BITS-1:0]));
            if (i_m_tvalid && i_m_tready) begin
                if (circles_due.size() == 0) begin
                    report_mismatch("unexpected beat", i_m_tdata[63:0], 0);
                end else begin
                    want = circles_due.pop_front();
                    if (i_m_tdata[0 +: CENTRE_W] !== want.centre_x)
                        report_mismatch("center_x", i_m_tdata[0 +: CENTRE_W],
                                        want.centre_x);
                    if (i_m_tdata[CENTRE_W +: CENTRE_W] !== want.centre_y)
                        report_mismatch("center_y", i_m_tdata[CENTRE_W +: CENTRE_W],
                                        want.centre_y);
                    if (i_m_tdata[2*CENTRE_W +: RADIUS_W] !== want.radius)
                        report_mismatch("radius_q4", i_m_tdata[2*CENTRE_W +: RADIUS_W],
                                        want.radius);
                    if (i_m_tuser !== want.collinear)
                        report_mismatch("collinear", i_m_tuser, want.collinear);
                end
            end
            due_count = circles_due.size();
        end
    end

endmodule

// ===== tb/circle_from_three_points_core_tb.sv =====
// testbench top for the circumcircle block: stimulus, stalls and verdict
`timescale 1ns / 100ps

module circle_from_three_points_core_tb;

    import cfp_pkg::*;

    localparam int CB       = 12;
    localparam int FB       = 4;
    localparam int CMAX     = (1 << CB) - 1;
    localparam int IN_W     = ((6*CB+7)/8)*8;
    localparam int OUT_W    = ((2*CENTRE_W+RADIUS_W+7)/8)*8;
    localparam int LATENCY  = 2*(3*CB+5+FB) + (3*CB+4) + 11;
    localparam int N_RANDOM = 1750;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;
    int               fail_count;
    int               pending;
    int               stall_left = 0;
    bit               no_stall = 1'b0;
    bit               no_gap = 1'b0;

    always #5 i_clk = ~i_clk;

    circle_from_three_points_core #(.COORD_BITS(CB), .RADIUS_FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    circle_from_three_points_core_checker #(.COORD_BITS(CB), .RADIUS_FRAC_BITS(FB)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random wait before each result beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (m_tready && m_tvalid) begin
            stall_left = no_stall ? 0 : $urandom_range(0, 13);
            m_tready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one input beat, then a random gap
    task automatic send_points(input int ax, ay, bx, by, cx, cy);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {cy[CB-1:0], cx[CB-1:0], by[CB-1:0], bx[CB-1:0],
                     ay[CB-1:0], ax[CB-1:0]};
        do @(posedge i_clk); while (!s_tready);
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int clip(input int v);
        return (v < 0) ? 0 : (v > CMAX) ? CMAX : v;
    endfunction

    initial begin
        int ax, ay, bx, by, dx, dy, kind;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, collinear, ties, near-degenerate triangles
        send_points(0, 0, 0, 0, 0, 0);
        send_points(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_points(0, 0, CMAX, 0, 0, CMAX);
        send_points(CMAX, CMAX, 0, CMAX, CMAX, 0);
        send_points(0, 0, CMAX, CMAX, 0, CMAX);
        send_points(0, 0, 1, 0, 0, 1);
        send_points(0, 0, 1, 0, 0, 3);
        send_points(0, 0, 2, 0, 0, 2);
        send_points(1, 1, 2, 2, 3, 3);
        send_points(0, 0, 2048, 2048, CMAX, CMAX);
        send_points(0, 0, CMAX, 1, CMAX - 1, 1);
        send_points(0, 0, CMAX, 1, 1, 0);
        send_points(CMAX, 0, 0, 1, 1, 1);
        send_points(0, CMAX, 1, 0, 0, CMAX - 1);
        send_points(0, 0, CMAX, CMAX - 1, CMAX - 1, CMAX - 2);
        send_points(100, 100, 100, 200, 100, 300);
        send_points(5, 7, 5, 7, 9, 11);
        send_points(2047, 0, 0, 2047, CMAX, 2048);
        send_points(CMAX, 0, CMAX, CMAX, 0, 0);

        // random: uniform, small clusters, collinear runs, corner values
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 400 == 0) begin
                no_stall = ($urandom_range(0, 1) == 1);
                no_gap   = ($urandom_range(0, 1) == 1);
            end
            if (n == N_RANDOM / 2) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            kind = $urandom_range(0, 9);
            ax = $urandom_range(0, CMAX);
            ay = $urandom_range(0, CMAX);
            if (kind < 6) begin
                send_points(ax, ay, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                            $urandom_range(0, CMAX), $urandom_range(0, CMAX));
            end else if (kind < 8) begin
                send_points(ax, ay, clip(ax + $urandom_range(0, 6) - 3),
                            clip(ay + $urandom_range(0, 6) - 3),
                            clip(ax + $urandom_range(0, 6) - 3),
                            clip(ay + $urandom_range(0, 6) - 3));
            end else if (kind == 8) begin
                dx = $urandom_range(0, 40) - 20;
                dy = $urandom_range(0, 40) - 20;
                bx = clip(ax + dx);
                by = clip(ay + dy);
                if (bx == ax + dx && by == ay + dy)
                    send_points(ax, ay, bx, by, clip(ax + 2 * dx), clip(ay + 2 * dy));
                else
                    send_points(ax, ay, ax, ay, ax, ay);
            end else begin
                send_points($urandom_range(0, 1) * CMAX, $urandom_range(0, 1) * CMAX,
                            $urandom_range(0, 1) * CMAX, $urandom_range(0, 1) * CMAX,
                            ax, ay);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then watch for stray beats
        wait (pending == 0);
        repeat (LATENCY + 50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
